// ===== hw/rtl/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the frame step timer: register indexes,
// field widths, reset values, divider operand codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

   // field widths
   localparam int FREQ_W      = 32;
   localparam int STEP_W      = 24;
   localparam int COUNT_W     = 64;
   localparam int FRAME_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_COUNTER_FREQUENCY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIXED_STEP_MODE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_STEP_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_LIMIT_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_COUNT       = 3'd4;

   // configuration reset values
   localparam logic [FREQ_W-1:0]  FREQ_RST   = 32'd10000000;
   localparam logic               MODE_RST   = 1'b1;
   localparam logic [STEP_W-1:0]  TARGET_RST = 24'd166667;
   localparam logic [STEP_W-1:0]  LIMIT_RST  = 24'd0;
   localparam logic [COUNT_W-1:0] START_RST  = 64'd0;

   // constant divisors
   localparam int SnapDivisor  = 4000;
   localparam int ClampDivisor = 10;

   // divider operand select
   localparam logic [1:0] DIV_TICKS = 2'd0;
   localparam logic [1:0] DIV_STEP  = 2'd1;
   localparam logic [1:0] DIV_RATE  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       div_start;
      logic [1:0] div_sel;
      logic       clamp_load;
      logic       mul_load;
      logic       ticks_load;
      logic       sum_load;
      logic       apply;
      logic       rate_apply;
      logic       out_load;
   } fst_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic fixed_mode;
      logic target_zero;
      logic second_due;
   } fst_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_step_timer_unit.sv =====
// ----------------------------------------------------------------------------
// frame_step_timer_unit
// Fixed or variable timestep frame timer driven by free-running counter
// samples, one result transaction per sample.
// ----------------------------------------------------------------------------
// Each request carries one sample of a free-running counter; one response
// follows with the step state after that sample. A request is taken only
// while the unit is idle. Every sample divides for the tick conversion; a
// fixed-step quotient and crossing a one-second boundary each add one more
// division. Divisions by a variable pass through one shared 64-bit
// divider that retires one quotient bit per cycle; the clamp limit uses a
// reciprocal multiplication. The next request is taken once the previous
// result is in the response register, even if that response is still
// stalled; a result that has to wait for a still stalled response holds the
// unit for as long as that stall lasts. Register writes are taken at any
// time but belong in idle periods; a start_count write also reloads the
// previous sample.
`default_nettype none

module frame_step_timer_unit #(
   parameter int TICKS_PER_SECOND = 10000000
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [fst_pkg::COUNT_W-1:0]     req_counter_now,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_frame_fired,
   output logic [fst_pkg::STEP_W-1:0]           rsp_elapsed_ticks,
   output logic [fst_pkg::COUNT_W-1:0]          rsp_total_ticks,
   output logic [fst_pkg::FRAME_W-1:0]          rsp_frame_count,
   output logic [fst_pkg::FRAME_W-1:0]          rsp_frames_per_second,
   input  wire logic                            csr_write_enable,
   input  wire logic [fst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fst_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import fst_pkg::*;

   fst_cmd_type    cmd;
   fst_status_type status;

   // sequencer and handshakes
   fst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, state and result registers
   fst_dpath #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_counter_now       (req_counter_now),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_frame_fired       (rsp_frame_fired),
      .rsp_elapsed_ticks     (rsp_elapsed_ticks),
      .rsp_total_ticks       (rsp_total_ticks),
      .rsp_frame_count       (rsp_frame_count),
      .rsp_frames_per_second (rsp_frames_per_second)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/fst_div.sv =====
// ----------------------------------------------------------------------------
// fst_div
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_div #(
   parameter int DIVIDEND_W = 64,
   parameter int DIVISOR_W  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one trial subtraction per cycle
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fst_dpath.sv =====
// ----------------------------------------------------------------------------
// fst_dpath
// Datapath of the frame step timer: configuration registers, sample delta,
// clamp, tick conversion, step accounting, rate sampling and the result
// registers. Divisions go through one shared iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_dpath #(
   parameter int TICKS_PER_SECOND = 10000000
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [fst_pkg::COUNT_W-1:0]     req_counter_now,
   input  wire logic                            csr_write_enable,
   input  wire logic [fst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fst_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire fst_pkg::fst_cmd_type            cmd,
   output fst_pkg::fst_status_type              status,
   output logic                                 rsp_frame_fired,
   output logic [fst_pkg::STEP_W-1:0]           rsp_elapsed_ticks,
   output logic [fst_pkg::COUNT_W-1:0]          rsp_total_ticks,
   output logic [fst_pkg::FRAME_W-1:0]          rsp_frame_count,
   output logic [fst_pkg::FRAME_W-1:0]          rsp_frames_per_second
);

   import fst_pkg::*;

   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W = FREQ_W + TPS_W;
   localparam int CMP_W  = (TPS_W > STEP_W) ? TPS_W : STEP_W;
   localparam int SNAP   = TICKS_PER_SECOND / SnapDivisor;

   // reciprocal of the clamp divisor (ten), exact for every 32-bit frequency
   localparam logic [FREQ_W-1:0] CLAMP_RECIP = 32'hCCCC_CCCD;
   localparam int                CLAMP_SHIFT = 35;

   // configuration registers
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              mode_ff, mode_in;
   logic [STEP_W-1:0] target_ff, target_in;
   logic [STEP_W-1:0] limit_ff, limit_in;

   // persistent state
   logic [COUNT_W-1:0] last_count_ff, last_count_in;
   logic [COUNT_W-1:0] second_ff, second_in;
   logic [STEP_W-1:0]  leftover_ff, leftover_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [FRAME_W-1:0] counter_ff, counter_in;
   logic [FRAME_W-1:0] fis_ff, fis_in;
   logic [FRAME_W-1:0] rate_ff, rate_in;
   logic [STEP_W-1:0]  last_len_ff, last_len_in;
   logic               fired_ff, fired_in;

   // per-transaction working registers
   logic [COUNT_W-1:0] delta_ff, delta_in;
   logic [FREQ_W-1:0]  maxd_ff, maxd_in;
   logic [FREQ_W-1:0]  dclamp_ff, dclamp_in;
   logic [PROD_W-1:0]  product_ff, product_in;
   logic [TPS_W-1:0]   ticks_ff, ticks_in;
   logic [STEP_W-1:0]  sum_ff, sum_in;

   // result registers
   logic               out_fired_ff;
   logic [STEP_W-1:0]  out_elapsed_ff;
   logic [COUNT_W-1:0] out_total_ff;
   logic [FRAME_W-1:0] out_count_ff;
   logic [FRAME_W-1:0] out_fps_ff;

   // divider hookup
   logic [COUNT_W-1:0] div_dividend;
   logic [FREQ_W-1:0]  div_divisor;
   logic               div_done;
   logic [COUNT_W-1:0] div_quo;
   logic [FREQ_W-1:0]  div_rem;

   // combinational helpers
   logic [FREQ_W-1:0]   freq_eff;
   logic [2*FREQ_W-1:0] maxd_prod;
   logic [CMP_W-1:0]    ticks_ext;
   logic [CMP_W-1:0]    target_ext;
   logic [CMP_W-1:0]    tick_diff;
   logic [CMP_W-1:0]    ticks_use;
   logic [CMP_W:0]      raw_sum;
   logic                fixed_div;
   logic                fire_now;

   // zero frequency counts as one
   assign freq_eff  = (freq_ff == '0) ? FREQ_W'(1) : freq_ff;

   // clamp limit, frequency over ten
   assign maxd_prod = {{FREQ_W{1'b0}}, freq_eff} * {{FREQ_W{1'b0}}, CLAMP_RECIP};

   // snap to target and saturating accumulate
   assign ticks_ext  = CMP_W'(ticks_ff);
   assign target_ext = CMP_W'(target_ff);
   assign tick_diff  = (ticks_ext > target_ext) ? (ticks_ext - target_ext)
                                                : (target_ext - ticks_ext);
   assign ticks_use  = (mode_ff && (tick_diff < CMP_W'(SNAP))) ? target_ext : ticks_ext;
   assign raw_sum    = {1'b0, ticks_use} + (CMP_W+1)'(leftover_ff);
   assign fixed_div  = mode_ff && (target_ff != '0);

   // step decision
   always_comb begin
      if (fixed_div) begin
         fire_now = div_quo != '0;
      end else if (mode_ff) begin
         fire_now = 1'b0;
      end else begin
         fire_now = sum_ff >= limit_ff;
      end
   end

   // divider operand select
   always_comb begin
      case (cmd.div_sel)
         DIV_TICKS: begin
            div_dividend = COUNT_W'(product_ff);
            div_divisor  = freq_eff;
         end
         DIV_STEP: begin
            div_dividend = COUNT_W'(sum_ff);
            div_divisor  = FREQ_W'(target_ff);
         end
         DIV_RATE: begin
            div_dividend = second_ff;
            div_divisor  = freq_eff;
         end
         default: begin
            div_dividend = second_ff;
            div_divisor  = freq_eff;
         end
      endcase
   end

   fst_div #(
      .DIVIDEND_W (COUNT_W),
      .DIVISOR_W  (FREQ_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next state of configuration and persistent state
   always_comb begin
      freq_in       = freq_ff;
      mode_in       = mode_ff;
      target_in     = target_ff;
      limit_in      = limit_ff;
      last_count_in = last_count_ff;
      second_in     = second_ff;
      leftover_in   = leftover_ff;
      total_in      = total_ff;
      counter_in    = counter_ff;
      fis_in        = fis_ff;
      rate_in       = rate_ff;
      last_len_in   = last_len_ff;
      fired_in      = fired_ff;

      // register writes
      if (csr_write_enable) begin
         case (csr_index)
            REG_COUNTER_FREQUENCY: freq_in       = csr_write_data[FREQ_W-1:0];
            REG_FIXED_STEP_MODE:   mode_in       = csr_write_data[0];
            REG_TARGET_STEP_TICKS: target_in     = csr_write_data[STEP_W-1:0];
            REG_FRAME_LIMIT_TICKS: limit_in      = csr_write_data[STEP_W-1:0];
            REG_START_COUNT:       last_count_in = csr_write_data;
            default: ;
         endcase
      end

      // new sample
      if (cmd.accept) begin
         last_count_in = req_counter_now;
         second_in     = second_ff + (req_counter_now - last_count_ff);
      end

      // step accounting
      if (cmd.apply) begin
         fired_in = fire_now;
         if (fixed_div) begin
            leftover_in = div_rem[STEP_W-1:0];
            if (fire_now) begin
               last_len_in = target_ff;
               total_in    = total_ff + COUNT_W'(sum_ff - div_rem[STEP_W-1:0]);
               counter_in  = counter_ff + div_quo[FRAME_W-1:0];
            end
         end else if (mode_ff) begin
            leftover_in = sum_ff;
         end else if (fire_now) begin
            last_len_in = sum_ff;
            total_in    = total_ff + COUNT_W'(sum_ff);
            leftover_in = '0;
            counter_in  = counter_ff + FRAME_W'(1);
         end else begin
            leftover_in = sum_ff;
         end
         fis_in = fis_ff + FRAME_W'(fire_now);
      end

      // one second elapsed
      if (cmd.rate_apply) begin
         rate_in   = fis_ff;
         fis_in    = '0;
         second_in = COUNT_W'(div_rem);
      end
   end

   // working register next values
   assign delta_in   = cmd.accept ? (req_counter_now - last_count_ff) : delta_ff;
   assign maxd_in    = cmd.accept ? FREQ_W'(maxd_prod[2*FREQ_W-1:CLAMP_SHIFT]) : maxd_ff;
   assign dclamp_in  = !cmd.clamp_load ? dclamp_ff :
                       (delta_ff > COUNT_W'(maxd_ff)) ? maxd_ff : delta_ff[FREQ_W-1:0];
   assign product_in = cmd.mul_load
                       ? (PROD_W'(dclamp_ff) * PROD_W'(TICKS_PER_SECOND)) : product_ff;
   assign ticks_in   = cmd.ticks_load ? div_quo[TPS_W-1:0] : ticks_ff;
   assign sum_in     = !cmd.sum_load ? sum_ff :
                       (raw_sum > (CMP_W+1)'({STEP_W{1'b1}})) ? {STEP_W{1'b1}}
                                                              : raw_sum[STEP_W-1:0];

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff       <= FREQ_RST;
         mode_ff       <= MODE_RST;
         target_ff     <= TARGET_RST;
         limit_ff      <= LIMIT_RST;
         last_count_ff <= START_RST;
         second_ff     <= '0;
         leftover_ff   <= '0;
         total_ff      <= '0;
         counter_ff    <= '0;
         fis_ff        <= '0;
         rate_ff       <= '0;
         last_len_ff   <= '0;
         fired_ff      <= 1'b0;
      end else begin
         freq_ff       <= freq_in;
         mode_ff       <= mode_in;
         target_ff     <= target_in;
         limit_ff      <= limit_in;
         last_count_ff <= last_count_in;
         second_ff     <= second_in;
         leftover_ff   <= leftover_in;
         total_ff      <= total_in;
         counter_ff    <= counter_in;
         fis_ff        <= fis_in;
         rate_ff       <= rate_in;
         last_len_ff   <= last_len_in;
         fired_ff      <= fired_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      maxd_ff    <= maxd_in;
      dclamp_ff  <= dclamp_in;
      product_ff <= product_in;
      ticks_ff   <= ticks_in;
      sum_ff     <= sum_in;
   end

   // result registers, loaded only when the output side is free
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_fired_ff   <= fired_ff;
         out_elapsed_ff <= last_len_ff;
         out_total_ff   <= total_ff;
         out_count_ff   <= counter_ff;
         out_fps_ff     <= rate_ff;
      end
   end

   assign status.div_done    = div_done;
   assign status.fixed_mode  = mode_ff;
   assign status.target_zero = target_ff == '0;
   assign status.second_due  = second_ff >= COUNT_W'(freq_eff);

   assign rsp_frame_fired       = out_fired_ff;
   assign rsp_elapsed_ticks     = out_elapsed_ff;
   assign rsp_total_ticks       = out_total_ff;
   assign rsp_frame_count       = out_count_ff;
   assign rsp_frames_per_second = out_fps_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fst_ctrl
// Controller of the frame step timer: sequences one sample through clamp,
// tick conversion, step accounting and rate sampling, and owns both
// handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output fst_pkg::fst_cmd_type         cmd,
   input  wire fst_pkg::fst_status_type status
);

   import fst_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_CLAMP      = 4'd1;
   localparam logic [3:0] ST_MUL        = 4'd2;
   localparam logic [3:0] ST_TICK_START = 4'd3;
   localparam logic [3:0] ST_TICKS      = 4'd4;
   localparam logic [3:0] ST_SUM        = 4'd5;
   localparam logic [3:0] ST_STEP_START = 4'd6;
   localparam logic [3:0] ST_STEP_WAIT  = 4'd7;
   localparam logic [3:0] ST_APPLY      = 4'd8;
   localparam logic [3:0] ST_RATE_CHECK = 4'd9;
   localparam logic [3:0] ST_RATE_WAIT  = 4'd10;
   localparam logic [3:0] ST_OUT        = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;
   logic       out_free;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.accept = 1'b1;
               state_in   = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp_load = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_TICK_START;
         end
         ST_TICK_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TICKS;
            state_in      = ST_TICKS;
         end
         ST_TICKS: begin
            cmd.div_sel = DIV_TICKS;
            if (status.div_done) begin
               cmd.ticks_load = 1'b1;
               state_in       = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            state_in     = (status.fixed_mode && !status.target_zero) ? ST_STEP_START
                                                                      : ST_APPLY;
         end
         ST_STEP_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_STEP;
            state_in      = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            cmd.div_sel = DIV_STEP;
            if (status.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.div_sel = DIV_STEP;
            cmd.apply   = 1'b1;
            state_in    = ST_RATE_CHECK;
         end
         ST_RATE_CHECK: begin
            cmd.div_sel = DIV_RATE;
            if (status.second_due) begin
               cmd.div_start = 1'b1;
               state_in      = ST_RATE_WAIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RATE_WAIT: begin
            cmd.div_sel = DIV_RATE;
            if (status.div_done) begin
               cmd.rate_apply = 1'b1;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== tb/tb_frame_step_timer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_frame_step_timer_unit
// Self-checking bench for the frame step timer. Counter samples go out in
// bursts with random gaps while the response side stalls on its own pattern,
// including one long hold-off that backs the block up into its request port.
// A timer model in the bench predicts every response transaction and the
// monitor compares all fields in order. A directed set of samples comes first,
// then random phases with fresh register settings between them.
// ----------------------------------------------------------------------------
module tb_frame_step_timer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fst_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int TICKS           = 10000000;
   localparam logic [63:0] TICKS_64   = 64'(TICKS);
   localparam logic [63:0] SNAP_TICKS = TICKS_64 / SnapDivisor;
   localparam logic [63:0] CLAMP_DIV  = 64'(ClampDivisor);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam int SPARE_COUNT     = 3;
   localparam int RANDOM_ITEMS    = 400;
   localparam int HOLD_OFF_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int SETTLE_CYCLES   = 20;
   localparam int DRAIN_CYCLES    = 300;
   localparam int IDLE_LIMIT      = 200000;

   typedef struct packed {
      logic               fired;
      logic [STEP_W-1:0]  elapsed;
      logic [COUNT_W-1:0] total;
      logic [FRAME_W-1:0] count;
      logic [FRAME_W-1:0] fps;
   } frame_result_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COUNT_W-1:0]     req_counter_now = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_frame_fired;
   logic [STEP_W-1:0]      rsp_elapsed_ticks;
   logic [COUNT_W-1:0]     rsp_total_ticks;
   logic [FRAME_W-1:0]     rsp_frame_count;
   logic [FRAME_W-1:0]     rsp_frames_per_second;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // timer model: register copies and step state
   logic [FREQ_W-1:0]  cfg_freq;
   logic               cfg_fixed;
   logic [STEP_W-1:0]  cfg_target;
   logic [STEP_W-1:0]  cfg_limit;
   logic [COUNT_W-1:0] last_sample;
   logic [COUNT_W-1:0] raw_second_sum;
   logic [STEP_W-1:0]  leftover;
   logic [COUNT_W-1:0] stepped_total;
   logic [FRAME_W-1:0] steps_fired;
   logic [FRAME_W-1:0] frames_this_second;
   logic [FRAME_W-1:0] fps_sample;
   logic [STEP_W-1:0]  last_step_len;

   // stimulus and scoreboard storage
   logic [COUNT_W-1:0] pending_samples[$];
   frame_result_type   expected_frames[$];
   logic [COUNT_W-1:0] next_sample_base;
   int                 random_items = 0;
   int                 errors = 0;
   int                 results_seen = 0;

   // driver and receiver pacing
   int                 burst_left = 0;
   int                 gap_left = 0;
   int                 hold_off_left = 0;
   logic               hold_off_done = 1'b0;
   int                 pattern_left = 0;
   stall_mode_type     stall_mode = STALL_NONE;

   frame_step_timer_unit #(
      .TICKS_PER_SECOND(TICKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_counter_now(req_counter_now),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_fired(rsp_frame_fired),
      .rsp_elapsed_ticks(rsp_elapsed_ticks),
      .rsp_total_ticks(rsp_total_ticks),
      .rsp_frame_count(rsp_frame_count),
      .rsp_frames_per_second(rsp_frames_per_second),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // advance the timer model by one counter sample
   task automatic advance_timer_model(input logic [COUNT_W-1:0] now_count,
                                      output frame_result_type res);
      logic [63:0] freq;
      logic [63:0] raw;
      logic [63:0] clamp_limit;
      logic [63:0] ticks;
      logic [63:0] target;
      logic [63:0] diff;
      logic [63:0] sum;
      logic [63:0] steps;
      logic [63:0] rest;
      logic        fired;
      freq = (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
      raw = now_count - last_sample;
      last_sample = now_count;
      raw_second_sum += raw;
      clamp_limit = freq / CLAMP_DIV;
      if (raw > clamp_limit) raw = clamp_limit;
      ticks = (raw * TICKS_64) / freq;
      target = 64'(cfg_target);
      fired = 1'b0;
      // snap near-target deltas in fixed mode
      if (cfg_fixed) begin
         diff = (ticks > target) ? ticks - target : target - ticks;
         if (diff < SNAP_TICKS) ticks = target;
      end
      sum = 64'(leftover) + ticks;
      if (sum > 64'hFF_FFFF) sum = 64'hFF_FFFF;
      if (cfg_fixed) begin
         if (target == '0) begin
            leftover = sum[STEP_W-1:0];
         end else begin
            steps = sum / target;
            rest = sum % target;
            leftover = rest[STEP_W-1:0];
            if (steps != '0) begin
               fired = 1'b1;
               last_step_len = cfg_target;
               stepped_total += steps * target;
               steps_fired += steps[FRAME_W-1:0];
            end
         end
      end else if (sum >= 64'(cfg_limit)) begin
         fired = 1'b1;
         last_step_len = sum[STEP_W-1:0];
         stepped_total += sum;
         leftover = '0;
         steps_fired += 1;
      end else begin
         leftover = sum[STEP_W-1:0];
      end
      // per-second rate sampling on raw counts
      if (fired) frames_this_second += 1;
      if (raw_second_sum >= freq) begin
         fps_sample = frames_this_second;
         frames_this_second = '0;
         raw_second_sum = raw_second_sum % freq;
      end
      res.fired = fired;
      res.elapsed = last_step_len;
      res.total = stepped_total;
      res.count = steps_fired;
      res.fps = fps_sample;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // register write while idle, mirrored into the model
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         REG_COUNTER_FREQUENCY: cfg_freq = data[FREQ_W-1:0];
         REG_FIXED_STEP_MODE:   cfg_fixed = data[0];
         REG_TARGET_STEP_TICKS: cfg_target = data[STEP_W-1:0];
         REG_FRAME_LIMIT_TICKS: cfg_limit = data[STEP_W-1:0];
         REG_START_COUNT:       last_sample = data;
         default: ;
      endcase
      next_sample_base = last_sample;
   endtask

   // unused upper data bits get random content now and then
   function automatic logic [63:0] with_noise(input logic [63:0] value, input int width);
      logic [63:0] noise;
      logic [63:0] keep;
      noise = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) noise = '0;
      keep = (64'd1 << width) - 1;
      return (noise & ~keep) | (value & keep);
   endfunction

   function automatic void queue_at(input logic [COUNT_W-1:0] value);
      pending_samples.push_back(value);
      next_sample_base = value;
   endfunction

   function automatic void queue_after(input logic [COUNT_W-1:0] delta);
      queue_at(next_sample_base + delta);
   endfunction

   // wait until every sample is answered, then let the block settle
   task automatic finish_phase();
      int waited;
      waited = 0;
      while ((pending_samples.size() != 0 || req_valid || expected_frames.size() != 0)
             && waited < IDLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= IDLE_LIMIT) begin
         $display("%0t responses still outstanding: %0d", $time, expected_frames.size());
         errors++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // fresh register settings, extremes included
   task automatic pick_timer_settings();
      logic [FREQ_W-1:0]      freq;
      logic [STEP_W-1:0]      target;
      logic [STEP_W-1:0]      limit;
      logic [CSR_INDEX_W-1:0] spare;
      case ($urandom_range(0, 9))
         0: freq = '0;
         1: freq = 32'd1;
         2: freq = $urandom_range(2, 9);
         3: freq = 32'd10;
         4: freq = '1;
         5, 6: freq = 32'd10000000;
         default: freq = $urandom_range(1000, 50000000);
      endcase
      case ($urandom_range(0, 7))
         0: target = '0;
         1: target = 24'd1;
         2: target = '1;
         3: target = 24'd10000000;
         default: target = STEP_W'($urandom_range(2500, 400000));
      endcase
      case ($urandom_range(0, 5))
         0: limit = '0;
         1: limit = '1;
         2: limit = 24'd10000000;
         default: limit = STEP_W'($urandom_range(1, 400000));
      endcase
      write_reg(REG_COUNTER_FREQUENCY, with_noise(64'(freq), FREQ_W));
      write_reg(REG_FIXED_STEP_MODE, with_noise(64'($urandom_range(0, 1)), 1));
      write_reg(REG_TARGET_STEP_TICKS, with_noise(64'(target), STEP_W));
      write_reg(REG_FRAME_LIMIT_TICKS, with_noise(64'(limit), STEP_W));
      if ($urandom_range(0, 3) == 0)
         write_reg(REG_START_COUNT, ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '1);
      if ($urandom_range(0, 5) == 0) begin
         spare = REG_SPARE_FIRST + CSR_INDEX_W'($urandom_range(0, SPARE_COUNT - 1));
         write_reg(spare, {$urandom, $urandom});
      end
   endtask

   // mostly frame-paced samples, plus clamp edges, stalls, wraps and noise
   task automatic queue_random_samples(input int count);
      logic [63:0] freq;
      logic [63:0] period;
      logic [63:0] snap_raw;
      logic [63:0] delta;
      int          pick;
      freq = (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
      snap_raw = freq * SNAP_TICKS / TICKS_64;
      if (cfg_fixed) period = 64'(cfg_target) * freq / TICKS_64;
      else period = 64'(cfg_limit) * freq / TICKS_64 / 4 + 1;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) delta = period + $urandom_range(0, 2 * snap_raw[31:0]) - snap_raw;
         else if (pick < 70) delta = {$urandom, $urandom} % (2 * period + 2);
         else if (pick < 80) delta = freq / CLAMP_DIV + $urandom_range(0, 2) - 1;
         else if (pick < 85) delta = '0;
         else if (pick < 92) delta = {$urandom, $urandom} - next_sample_base;
         else delta = {$urandom, $urandom} >> $urandom_range(0, 40);
         queue_after(delta);
         random_items++;
      end
   endtask

   // request driver: bursts of transactions with random gaps
   always @(posedge clock) begin
      frame_result_type prediction;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_timer_model(req_counter_now, prediction);
            expected_frames.push_back(prediction);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_counter_now <= pending_samples.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                             $urandom_range(1, ($urandom_range(0, 2) == 0) ? 320 : 24);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 200);
         end
         pattern_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
            default:     rsp_stall <= (pattern_left % 3 != 0);
         endcase
      end
   end

   // response monitor against the oldest prediction
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_frames.size() == 0) begin
            $display("%0t response transaction with no sample outstanding", $time);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            check_field("frame_fired", 64'(want.fired), 64'(rsp_frame_fired));
            check_field("elapsed_ticks", 64'(want.elapsed), 64'(rsp_elapsed_ticks));
            check_field("total_ticks", want.total, rsp_total_ticks);
            check_field("frame_count", 64'(want.count), 64'(rsp_frame_count));
            check_field("frames_per_second", 64'(want.fps), 64'(rsp_frames_per_second));
         end
      end
   end

   // stimulus sequence
   initial begin
      cfg_freq = FREQ_RST;
      cfg_fixed = MODE_RST;
      cfg_target = TARGET_RST;
      cfg_limit = LIMIT_RST;
      last_sample = START_RST;
      raw_second_sum = '0;
      leftover = '0;
      stepped_total = '0;
      steps_fired = '0;
      frames_this_second = '0;
      fps_sample = '0;
      last_step_len = '0;
      next_sample_base = START_RST;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: snap window edges, clamp, counter wrap
      queue_after(64'd0);
      queue_after(64'd166667);
      queue_after(64'd168667);
      queue_after(64'd169667);
      queue_after(64'd164168);
      queue_after(64'd1000000);
      queue_after(64'd50000000);
      queue_at('1);
      queue_at(64'd5);
      queue_at(64'h8000_0000_0000_0000);
      finish_phase();

      // zero frequency behaves as one
      write_reg(REG_COUNTER_FREQUENCY, 64'd0);
      queue_after(64'd1);
      queue_after(64'd3);
      queue_after(64'd0);
      finish_phase();

      // frequency below ten, no ticks advance
      write_reg(REG_COUNTER_FREQUENCY, 64'd5);
      queue_after(64'd2);
      queue_after(64'd100);
      finish_phase();

      // widest frequency, variable mode with zero frame limit
      write_reg(REG_COUNTER_FREQUENCY, 64'hFFFF_FFFF);
      write_reg(REG_FIXED_STEP_MODE, 64'd0);
      write_reg(REG_FRAME_LIMIT_TICKS, 64'd0);
      queue_after(64'd0);
      queue_after(64'd429496729);
      queue_after(64'h1_0000_0000);
      finish_phase();

      // start count reload, smallest and largest targets
      write_reg(REG_START_COUNT, '1);
      write_reg(REG_COUNTER_FREQUENCY, 64'd10000000);
      write_reg(REG_FIXED_STEP_MODE, 64'd1);
      write_reg(REG_TARGET_STEP_TICKS, 64'd1);
      queue_after(64'd1);
      queue_after(64'd1000000);
      finish_phase();
      write_reg(REG_TARGET_STEP_TICKS, 64'hFF_FFFF);
      queue_after(64'd166667);
      finish_phase();

      // zero target saturates the leftover, kept across the mode change
      write_reg(REG_TARGET_STEP_TICKS, 64'd0);
      repeat (18) begin
         queue_after(64'd1000000 + $urandom_range(0, 5000000));
         random_items++;
      end
      finish_phase();
      write_reg(REG_FIXED_STEP_MODE, 64'd0);
      write_reg(REG_FRAME_LIMIT_TICKS, 64'hFF_FFFF);
      repeat (2) begin
         queue_after(64'($urandom_range(0, 2000000)));
         random_items++;
      end
      finish_phase();

      // random phases
      while (random_items < RANDOM_ITEMS) begin
         pick_timer_settings();
         queue_random_samples($urandom_range(15, 45));
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
